// ----- rtl/core/mll_pkg.sv -----
// Package for the mutex lock manager: sizes, request and status codes, table entry type.
`timescale 1ns / 1ps
package mll_pkg;

	localparam int MUTEX_COUNT = 16;
	localparam int WAIT_DEPTH  = 16;
	localparam int PID_BITS    = 4;

	// fixed field widths of the ports
	localparam int REQ_W    = 2;
	localparam int ID_W     = 4;
	localparam int PIDIN_W  = 4;
	localparam int STATUS_W = 3;
	localparam int VALUE_W  = 5;

	localparam int MID_W  = $clog2(MUTEX_COUNT);
	localparam int WPTR_W = $clog2(WAIT_DEPTH);
	localparam int CNT_W  = $clog2(WAIT_DEPTH + 2);
	localparam int FCNT_W = $clog2(MUTEX_COUNT + 1);
	localparam int WADDR_W = MID_W + WPTR_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_DESTROY = 2'd1,
		REQ_LOCK    = 2'd2,
		REQ_UNLOCK  = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_NO_FREE = 3'd1,
		ST_BAD_ID  = 3'd2,
		ST_LOCKED  = 3'd3,
		ST_Q_FULL  = 3'd4
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

	typedef struct packed {
		logic                alloc;
		logic [CNT_W-1:0]    cnt;
		logic [PID_BITS-1:0] owner;
		logic [WPTR_W-1:0]   tail;
	} tbl_ent_t;

	typedef struct packed {
		req_t                 req;
		logic [ID_W-1:0]      id;
		logic [PID_BITS-1:0]  pid;
	} req_item_t;

endpackage

// ----- rtl/core/mutex_lock_manager.sv -----
// Mutex lock manager: mutex table, free id list and per-mutex waiter queues in memory.
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// request   in         in_valid/in_stall   req_type, mutex_id, requester_pid
// result    out        out_valid/out_stall status, value, must_wait, owner_handed, new_owner_pid
//
// The accept edge issues the table, free list and waiter reads; the edge that ends
// the execute state does the read-modify-write and loads the result register.
// Reset is immediate: valid bits make unwritten table and free list entries read
// as their reset values, so there is no clearing pass.
// A result held by out_stall keeps the block in its execute cycle until taken.
module mutex_lock_manager (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mll_pkg::REQ_W-1:0]      req_type,
	input  logic [mll_pkg::ID_W-1:0]       mutex_id,
	input  logic [mll_pkg::PIDIN_W-1:0]    requester_pid,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mll_pkg::STATUS_W-1:0]   status,
	output logic [mll_pkg::VALUE_W-1:0]    value,
	output logic                           must_wait,
	output logic                           owner_handed,
	output logic [mll_pkg::PIDIN_W-1:0]    new_owner_pid
);
	import mll_pkg::*;

	fsm_t state_q, state_nxt;
	logic in_fire, exec_go;

	req_item_t req_s1;

	// memories
	tbl_ent_t          tbl_mem [MUTEX_COUNT];
	logic [MID_W-1:0]  free_mem [MUTEX_COUNT];
	logic [PID_BITS-1:0] wait_mem [MUTEX_COUNT * WAIT_DEPTH];

	logic [MUTEX_COUNT-1:0] tbl_vld_q;
	logic [MUTEX_COUNT-1:0] free_vld_q;
	logic [WPTR_W-1:0]      head_q [MUTEX_COUNT];

	logic [MID_W-1:0]  free_head_q, free_tail_q;
	logic [FCNT_W-1:0] free_cnt_q;

	tbl_ent_t            tbl_rd_s1;
	logic                tbl_vld_s1;
	logic [MID_W-1:0]    free_rd_s1;
	logic                free_vld_s1;
	logic [PID_BITS-1:0] wait_rd_s1;

	logic [MID_W-1:0]   rd_id;
	logic [WADDR_W-1:0] wait_raddr;

	// execute-cycle controls
	tbl_ent_t            ent;
	logic [MID_W-1:0]    got_id;
	logic [MID_W-1:0]    ex_id;
	logic                id_ok;
	logic                tbl_we;
	logic [MID_W-1:0]    tbl_waddr;
	tbl_ent_t            tbl_wdata;
	logic                head_we;
	logic [WPTR_W-1:0]   head_wdata;
	logic                wait_we;
	logic                free_pop, free_push;
	status_t             r_status;
	logic [VALUE_W-1:0]  r_value;
	logic                r_wait, r_handed;
	logic [PID_BITS-1:0] r_newpid;

	function automatic logic [WPTR_W-1:0] wptr_inc(input logic [WPTR_W-1:0] p);
		return (int'(p) == WAIT_DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [MID_W-1:0] fptr_inc(input logic [MID_W-1:0] p);
		return (int'(p) == MUTEX_COUNT - 1) ? '0 : p + 1'b1;
	endfunction

	// state machine
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: if (in_valid) state_nxt = FSM_EXEC;
			FSM_EXEC: if (exec_go) state_nxt = FSM_IDLE;
			default:  state_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		exec_go  = 1'b0;
		case (state_q)
			FSM_IDLE: in_stall = 1'b0;
			FSM_EXEC: exec_go  = !out_valid || !out_stall;
			default: begin
				in_stall = 1'b1;
				exec_go  = 1'b0;
			end
		endcase
	end

	assign in_fire = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else         state_q <= state_nxt;
	end

	// read issue on accept
	assign rd_id      = mutex_id[MID_W-1:0];
	assign wait_raddr = {rd_id, head_q[rd_id]};

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1.req  <= req_t'(req_type);
			req_s1.id   <= mutex_id;
			req_s1.pid  <= requester_pid[PID_BITS-1:0];
			tbl_rd_s1   <= tbl_mem[rd_id];
			tbl_vld_s1  <= tbl_vld_q[rd_id];
			free_rd_s1  <= free_mem[free_head_q];
			free_vld_s1 <= free_vld_q[free_head_q];
			wait_rd_s1  <= wait_mem[wait_raddr];
		end
	end

	// execute: modify
	assign ent    = tbl_vld_s1 ? tbl_rd_s1 : '0;
	assign got_id = free_vld_s1 ? free_rd_s1 : free_head_q;
	assign ex_id  = req_s1.id[MID_W-1:0];
	assign id_ok  = (int'(req_s1.id) < MUTEX_COUNT) && ent.alloc;

	always_comb begin
		tbl_we     = 1'b0;
		tbl_waddr  = ex_id;
		tbl_wdata  = ent;
		head_we    = 1'b0;
		head_wdata = '0;
		wait_we    = 1'b0;
		free_pop   = 1'b0;
		free_push  = 1'b0;
		r_status   = ST_OK;
		r_value    = '0;
		r_wait     = 1'b0;
		r_handed   = 1'b0;
		r_newpid   = '0;
		case (req_s1.req)
			REQ_ALLOC: begin
				if (free_cnt_q == '0) begin
					r_status = ST_NO_FREE;
				end else begin
					free_pop        = 1'b1;
					tbl_we          = 1'b1;
					tbl_waddr       = got_id;
					tbl_wdata       = '0;
					tbl_wdata.alloc = 1'b1;
					r_value         = VALUE_W'(got_id);
				end
			end
			REQ_DESTROY: begin
				if (!id_ok) begin
					r_status = ST_BAD_ID;
				end else if (ent.cnt != '0) begin
					r_status = ST_LOCKED;
					r_value  = VALUE_W'(ent.cnt);
				end else begin
					free_push = (int'(free_cnt_q) < MUTEX_COUNT);
					tbl_we    = 1'b1;
					tbl_wdata = '0;
					head_we   = 1'b1;
				end
			end
			REQ_LOCK: begin
				if (!id_ok) begin
					r_status = ST_BAD_ID;
				end else if (ent.cnt == '0) begin
					tbl_we          = 1'b1;
					tbl_wdata.owner = req_s1.pid;
					tbl_wdata.cnt   = CNT_W'(1);
					r_value         = VALUE_W'(1);
				end else if (int'(ent.cnt) > WAIT_DEPTH) begin
					r_status = ST_Q_FULL;
					r_value  = VALUE_W'(ent.cnt);
				end else begin
					wait_we        = 1'b1;
					tbl_we         = 1'b1;
					tbl_wdata.tail = wptr_inc(ent.tail);
					tbl_wdata.cnt  = ent.cnt + 1'b1;
					r_value        = VALUE_W'(ent.cnt + 1'b1);
					r_wait         = 1'b1;
				end
			end
			REQ_UNLOCK: begin
				if (!id_ok) begin
					r_status = ST_BAD_ID;
				end else if (ent.cnt != '0) begin
					tbl_we        = 1'b1;
					tbl_wdata.cnt = ent.cnt - 1'b1;
					r_value       = VALUE_W'(ent.cnt - 1'b1);
					if (ent.cnt == CNT_W'(1)) begin
						tbl_wdata.owner = '0;
					end else begin
						// oldest waiter takes over
						tbl_wdata.owner = wait_rd_s1;
						head_we         = 1'b1;
						head_wdata      = wptr_inc(head_q[ex_id]);
						r_handed        = 1'b1;
						r_newpid        = wait_rd_s1;
					end
				end
			end
			default: r_status = ST_OK;
		endcase
	end

	// execute: write back
	always_ff @(posedge clk) begin
		if (exec_go && tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
		if (exec_go && wait_we) wait_mem[{ex_id, ent.tail}] <= req_s1.pid;
		if (exec_go && free_push) free_mem[free_tail_q] <= ex_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q   <= '0;
			free_vld_q  <= '0;
			free_head_q <= '0;
			free_tail_q <= '0;
			free_cnt_q  <= FCNT_W'(MUTEX_COUNT);
			for (int i = 0; i < MUTEX_COUNT; i++) head_q[i] <= '0;
		end else if (exec_go) begin
			if (tbl_we) tbl_vld_q[tbl_waddr] <= 1'b1;
			if (free_pop) begin
				free_head_q <= fptr_inc(free_head_q);
				free_cnt_q  <= free_cnt_q - 1'b1;
				head_q[got_id] <= '0;
			end
			if (free_push) begin
				free_vld_q[free_tail_q] <= 1'b1;
				free_tail_q <= fptr_inc(free_tail_q);
				free_cnt_q  <= free_cnt_q + 1'b1;
			end
			if (head_we) head_q[ex_id] <= head_wdata;
		end
	end

	// result register
	logic                out_valid_q;
	status_t             status_q;
	logic [VALUE_W-1:0]  value_q;
	logic                wait_q, handed_q;
	logic [PID_BITS-1:0] newpid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                     out_valid_q <= 1'b0;
		else if (exec_go)                out_valid_q <= 1'b1;
		else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q <= r_status;
			value_q  <= r_value;
			wait_q   <= r_wait;
			handed_q <= r_handed;
			newpid_q <= r_newpid;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign value         = value_q;
	assign must_wait     = wait_q;
	assign owner_handed  = handed_q;
	assign new_owner_pid = PIDIN_W'(newpid_q);

endmodule

// ----- dv/mutex_lock_manager_tb.sv -----
// Self-checking testbench for the mutex lock manager: directed table, then random request bursts.
`timescale 1ns / 1ps
module mutex_lock_manager_tb;
	import mll_pkg::*;

	localparam int RAND_PER_PHASE = 195;
	localparam int STALL_LIMIT    = 5000;

	typedef struct packed {
		status_t              status;
		logic [VALUE_W-1:0]   value;
		logic                 must_wait;
		logic                 owner_handed;
		logic [PIDIN_W-1:0]   new_owner;
	} mutex_result_t;

	typedef struct {
		req_t                 req;
		logic [ID_W-1:0]      id;
		logic [PIDIN_W-1:0]   pid;
		int                   reps;
		bit                   typed;
		mutex_result_t        res;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [REQ_W-1:0]      req_type = '0;
	logic [ID_W-1:0]       mutex_id = '0;
	logic [PIDIN_W-1:0]    requester_pid = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [VALUE_W-1:0]    value;
	logic                  must_wait;
	logic                  owner_handed;
	logic [PIDIN_W-1:0]    new_owner_pid;

	// mirror of the mutex table
	bit                    is_alloc [MUTEX_COUNT];
	int                    held_cnt [MUTEX_COUNT];
	logic [PIDIN_W-1:0]    owner_of [MUTEX_COUNT];
	logic [PIDIN_W-1:0]    waiters  [MUTEX_COUNT][WAIT_DEPTH];
	int                    wait_rd  [MUTEX_COUNT];
	int                    wait_wr  [MUTEX_COUNT];
	logic [ID_W-1:0]       free_ids [MUTEX_COUNT];
	int                    free_rd, free_wr, free_cnt;

	mutex_result_t         pending_results[$];
	stim_row_t             dir_rows[$];
	int                    errors, sent_items, idle_cycles;
	int                    idle_pct, stall_pct;
	int                    req_seen [4];
	int                    status_seen [5];
	int                    handoffs;

	mutex_lock_manager i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.mutex_id      (mutex_id),
		.requester_pid (requester_pid),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.value         (value),
		.must_wait     (must_wait),
		.owner_handed  (owner_handed),
		.new_owner_pid (new_owner_pid)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(string what, int exp_v, int got_v);
		$display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, exp_v, got_v);
		errors++;
	endtask

	function automatic mutex_result_t apply_request(req_t r, logic [ID_W-1:0] id,
			logic [PIDIN_W-1:0] pid);
		mutex_result_t res;
		int c;
		logic [PIDIN_W-1:0] p;
		res = '0;
		c = held_cnt[id];
		if (r == REQ_ALLOC) begin
			if (free_cnt == 0) begin
				res.status = ST_NO_FREE;
			end else begin
				res.value = VALUE_W'(free_ids[free_rd]);
				is_alloc[free_ids[free_rd]] = 1'b1;
				free_rd = (free_rd + 1) % MUTEX_COUNT;
				free_cnt--;
			end
		end else if (!is_alloc[id]) begin
			res.status = ST_BAD_ID;
		end else if (r == REQ_DESTROY) begin
			if (c > 0) begin
				res.status = ST_LOCKED;
				res.value = VALUE_W'(c);
			end else begin
				if (free_cnt < MUTEX_COUNT) begin
					free_ids[free_wr] = id;
					free_wr = (free_wr + 1) % MUTEX_COUNT;
					free_cnt++;
				end
				is_alloc[id] = 1'b0;
				owner_of[id] = '0;
				wait_rd[id] = 0;
				wait_wr[id] = 0;
			end
		end else if (r == REQ_LOCK) begin
			if (c == 0) begin
				owner_of[id] = pid;
				held_cnt[id] = 1;
				res.value = VALUE_W'(1);
			end else if (c - 1 >= WAIT_DEPTH) begin
				res.status = ST_Q_FULL;
				res.value = VALUE_W'(c);
			end else begin
				waiters[id][wait_wr[id]] = pid;
				wait_wr[id] = (wait_wr[id] + 1) % WAIT_DEPTH;
				held_cnt[id] = c + 1;
				res.value = VALUE_W'(c + 1);
				res.must_wait = 1'b1;
			end
		end else if (c != 0) begin
			c--;
			held_cnt[id] = c;
			if (c == 0) begin
				owner_of[id] = '0;
			end else begin
				p = waiters[id][wait_rd[id]];
				wait_rd[id] = (wait_rd[id] + 1) % WAIT_DEPTH;
				owner_of[id] = p;
				res.owner_handed = 1'b1;
				res.new_owner = p;
			end
			res.value = VALUE_W'(c);
		end
		return res;
	endfunction

	// returns an allocated id when there is one, else any id
	function automatic logic [ID_W-1:0] pick_live_id();
		int start, k;
		logic [ID_W-1:0] cand;
		start = $urandom_range(0, MUTEX_COUNT - 1);
		for (k = 0; k < MUTEX_COUNT; k++) begin
			cand = ID_W'((start + k) % MUTEX_COUNT);
			if (is_alloc[cand])
				return cand;
		end
		return start[ID_W-1:0];
	endfunction

	task automatic add_row(req_t r, int id, int pid, int reps, bit typed,
			status_t st, int val, bit wt, bit hd, int np);
		stim_row_t row;
		row.req = r;
		row.id = ID_W'(id);
		row.pid = PIDIN_W'(pid);
		row.reps = reps;
		row.typed = typed;
		row.res = '{st, val[VALUE_W-1:0], wt, hd, np[PIDIN_W-1:0]};
		dir_rows.push_back(row);
	endtask

	// called at a rising edge; returns at the edge where the item is accepted
	task automatic send_req(req_t r, logic [ID_W-1:0] id, logic [PIDIN_W-1:0] pid,
			bit typed, mutex_result_t typed_res);
		mutex_result_t predicted;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r;
		mutex_id <= id;
		requester_pid <= pid;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predicted = apply_request(r, id, pid);
		pending_results.push_back(typed ? typed_res : predicted);
		req_seen[r]++;
		sent_items++;
	endtask

	task automatic random_burst();
		int kind, n, k;
		logic [ID_W-1:0] id;
		kind = $urandom_range(0, 9);
		id = pick_live_id();
		case (kind)
			0: begin
				repeat ($urandom_range(1, 5))
					send_req(req_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 15)),
						PIDIN_W'($urandom_range(0, 15)), 1'b0, '0);
			end
			1: begin
				repeat ($urandom_range(1, 18))
					send_req(REQ_ALLOC, ID_W'($urandom_range(0, 15)),
						PIDIN_W'($urandom_range(0, 15)), 1'b0, '0);
			end
			2: begin
				// pile up waiters, sometimes past the queue limit
				repeat ($urandom_range(2, 20))
					send_req(REQ_LOCK, id, PIDIN_W'($urandom_range(0, 15)), 1'b0, '0);
			end
			3: begin
				n = held_cnt[id] + $urandom_range(0, 1);
				repeat (n)
					send_req(REQ_UNLOCK, id, PIDIN_W'($urandom_range(0, 15)), 1'b0, '0);
				send_req(REQ_DESTROY, id, PIDIN_W'($urandom_range(0, 15)), 1'b0, '0);
			end
			default: begin
				repeat ($urandom_range(1, 8)) begin
					k = $urandom_range(0, 9);
					send_req(k < 5 ? REQ_LOCK : (k < 9 ? REQ_UNLOCK : REQ_DESTROY), id,
						PIDIN_W'($urandom_range(0, 15)), 1'b0, '0);
				end
			end
		endcase
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin : result_check
		mutex_result_t exp_r;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (status < 5)
				status_seen[status]++;
			if (owner_handed)
				handoffs++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", 0, status);
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status)
					report_mismatch("status", exp_r.status, status);
				if (value !== exp_r.value)
					report_mismatch("value", exp_r.value, value);
				if (must_wait !== exp_r.must_wait)
					report_mismatch("must_wait", exp_r.must_wait, must_wait);
				if (owner_handed !== exp_r.owner_handed)
					report_mismatch("owner_handed", exp_r.owner_handed, owner_handed);
				if (new_owner_pid !== exp_r.new_owner)
					report_mismatch("new_owner_pid", exp_r.new_owner, new_owner_pid);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int ph, target;
		errors = 0;
		sent_items = 0;
		idle_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		handoffs = 0;
		for (int i = 0; i < MUTEX_COUNT; i++) begin
			is_alloc[i] = 1'b0;
			held_cnt[i] = 0;
			owner_of[i] = '0;
			wait_rd[i] = 0;
			wait_wr[i] = 0;
			free_ids[i] = ID_W'(i);
		end
		free_rd = 0;
		free_wr = 0;
		free_cnt = MUTEX_COUNT;
		foreach (req_seen[i])
			req_seen[i] = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;

		add_row(REQ_ALLOC,    0,  0,  1, 1, ST_OK,      0, 0, 0, 0);
		add_row(REQ_DESTROY,  1,  0,  1, 1, ST_BAD_ID,  0, 0, 0, 0);
		add_row(REQ_LOCK,    15, 15,  1, 1, ST_BAD_ID,  0, 0, 0, 0);
		add_row(REQ_UNLOCK,   3,  0,  1, 1, ST_BAD_ID,  0, 0, 0, 0);
		add_row(REQ_UNLOCK,   0,  5,  1, 1, ST_OK,      0, 0, 0, 0);
		add_row(REQ_LOCK,     0, 15,  1, 1, ST_OK,      1, 0, 0, 0);
		add_row(REQ_LOCK,     0, 10,  1, 1, ST_OK,      2, 1, 0, 0);
		add_row(REQ_DESTROY,  0,  0,  1, 1, ST_LOCKED,  2, 0, 0, 0);
		// unlock by a non-owner still hands over
		add_row(REQ_UNLOCK,   0,  3,  1, 1, ST_OK,      1, 0, 1, 10);
		add_row(REQ_UNLOCK,   0, 15,  1, 1, ST_OK,      0, 0, 0, 0);
		add_row(REQ_DESTROY,  0,  0,  1, 1, ST_OK,      0, 0, 0, 0);
		add_row(REQ_ALLOC,    0,  0, 16, 0, ST_OK,      0, 0, 0, 0);
		add_row(REQ_ALLOC,    9,  6,  1, 1, ST_NO_FREE, 0, 0, 0, 0);
		add_row(REQ_LOCK,     7,  9, 17, 0, ST_OK,      0, 0, 0, 0);
		add_row(REQ_LOCK,     7,  4,  1, 1, ST_Q_FULL, 17, 0, 0, 0);
		add_row(REQ_UNLOCK,   7,  2, 17, 0, ST_OK,      0, 0, 0, 0);
		add_row(REQ_DESTROY,  7,  0,  1, 1, ST_OK,      0, 0, 0, 0);
		add_row(REQ_DESTROY,  7,  0,  1, 1, ST_BAD_ID,  0, 0, 0, 0);
		add_row(REQ_ALLOC,    0,  0,  1, 1, ST_OK,      7, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			repeat (dir_rows[r].reps)
				send_req(dir_rows[r].req, dir_rows[r].id, dir_rows[r].pid,
					dir_rows[r].typed, dir_rows[r].res);

		for (ph = 0; ph < 4; ph++) begin
			// hold off until the block has drained
			in_valid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 45; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 45; end
				default: begin idle_pct = 27; stall_pct = 27; end
			endcase
			target = sent_items + RAND_PER_PHASE;
			while (sent_items < target)
				random_burst();
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		stall_pct = 0;
		repeat (10) @(posedge clk);

		$display("Covered %0d requests: alloc %0d, destroy %0d, lock %0d, unlock %0d,",
			sent_items, req_seen[REQ_ALLOC], req_seen[REQ_DESTROY], req_seen[REQ_LOCK],
			req_seen[REQ_UNLOCK]);
		$display("four idle mixes; ok %0d, no free %0d, bad id %0d, locked %0d,",
			status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_BAD_ID],
			status_seen[ST_LOCKED]);
		$display("queue full %0d, handoffs %0d", status_seen[ST_Q_FULL], handoffs);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/mll_pkg.sv
rtl/core/mutex_lock_manager.sv
dv/mutex_lock_manager_tb.sv
